// ----- src/mmcs_pkg.sv -----
// Package for the min/max contrast stretch block.
// Holds sample widths, command codes and the item and job types. Depends on nothing.
`timescale 1ns / 1ps

package mmcs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = 16;
  localparam int NUM_BITS    = SAMPLE_BITS + OUT_BITS;

  localparam logic [OUT_BITS-1:0] OUT_FULL = 16'd65280;
  localparam logic [OUT_BITS-1:0] OUT_ZERO = 16'd0;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SCALE   = 1'b1;

  typedef enum logic [1:0] {
    JOB_ZERO   = 2'd0,
    JOB_FULL   = 2'd1,
    JOB_DIVIDE = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] pixel_sample;
    logic                          end_of_pass;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] scaled_pixel;
    logic                frame_done;
  } out_item_t;

  typedef struct packed {
    job_kind_t              kind;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] span;
    logic                   last;
  } job_t;

endpackage

// ----- src/mmcs_front.sv -----
// Front end: accepts samples, tracks the running minimum and maximum,
// classifies scale samples into jobs. Depends on mmcs_pkg.
`timescale 1ns / 1ps

module mmcs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmcs_pkg::in_item_t in_item,
  output logic               job_push,
  output mmcs_pkg::job_t     job_data,
  input  logic               queue_full
);

  localparam int SB = mmcs_pkg::SAMPLE_BITS;

  logic signed [SB-1:0] min_r, min_nxt;
  logic signed [SB-1:0] max_r, max_nxt;
  logic                 restart_r, restart_nxt;

  logic                 accept;
  logic                 is_scale;
  logic signed [SB-1:0] sample_w;
  logic signed [SB:0]   span_w;
  logic signed [SB:0]   diff_w;
  logic                 span_pos;
  logic                 above_min;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign is_scale = (in_item.command == mmcs_pkg::CMD_SCALE);
  assign sample_w = in_item.pixel_sample;

  assign span_w    = $signed({max_r[SB-1], max_r}) - $signed({min_r[SB-1], min_r});
  assign diff_w    = $signed({sample_w[SB-1], sample_w}) - $signed({min_r[SB-1], min_r});
  assign span_pos  = (max_r > min_r);
  assign above_min = (sample_w > min_r);

  // classify the scale sample against the current span
  always_comb begin
    job_data.diff = diff_w[SB-1:0];
    job_data.span = span_w[SB-1:0];
    job_data.last = in_item.end_of_pass;
    if (!span_pos || !above_min) begin
      job_data.kind = mmcs_pkg::JOB_ZERO;
    end else if (diff_w[SB-1:0] >= span_w[SB-1:0]) begin
      job_data.kind = mmcs_pkg::JOB_FULL;
    end else begin
      job_data.kind = mmcs_pkg::JOB_DIVIDE;
    end
  end

  assign job_push = accept && is_scale;

  always_comb begin
    min_nxt     = min_r;
    max_nxt     = max_r;
    restart_nxt = restart_r;
    if (accept && !is_scale) begin
      if (restart_r) begin
        min_nxt     = sample_w;
        max_nxt     = sample_w;
        restart_nxt = 1'b0;
      end else begin
        if (sample_w < min_r) min_nxt = sample_w;
        if (sample_w > max_r) max_nxt = sample_w;
      end
      if (in_item.end_of_pass) restart_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= mmcs_pkg::SAMPLE_TOP;
      max_r     <= mmcs_pkg::SAMPLE_BOTTOM;
      restart_r <= 1'b1;
    end else begin
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      restart_r <= restart_nxt;
    end
  end

endmodule

// ----- src/mmcs_queue.sv -----
// Short job queue between front end and scaler, flop based.
// Depends on mmcs_pkg for the job type.
`timescale 1ns / 1ps

module mmcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mmcs_pkg::job_t push_data,
  input  logic           pop,
  output mmcs_pkg::job_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmcs_pkg::job_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");

endmodule

// ----- src/mmcs_scaler.sv -----
// Back end: pops jobs, runs the restoring divider for (diff*65280)/span,
// and holds the result in the output register. Depends on mmcs_pkg.
`timescale 1ns / 1ps

module mmcs_scaler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  mmcs_pkg::job_t      job_data,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mmcs_pkg::out_item_t out_item
);

  localparam int SB  = mmcs_pkg::SAMPLE_BITS;
  localparam int OB  = mmcs_pkg::OUT_BITS;
  localparam int NB  = mmcs_pkg::NUM_BITS;
  localparam int CNW = $clog2(OB);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SB-1:0]       diff_r, diff_nxt;
  logic [SB-1:0]       span_r, span_nxt;
  logic                last_r, last_nxt;
  logic [SB-1:0]       rem_r, rem_nxt;
  logic [OB-1:0]       num_lo_r, num_lo_nxt;
  logic [OB-1:0]       quot_r, quot_nxt;
  logic [CNW-1:0]      cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  mmcs_pkg::out_item_t out_data_r;

  logic [NB-1:0]       num_w;
  logic [SB:0]         trial_w;
  logic                ge_w;
  logic                load_out;

  // diff * 65280 = diff * 2^16 - diff * 2^8
  assign num_w   = {diff_r, {OB{1'b0}}} - {{(NB-SB-8){1'b0}}, diff_r, 8'd0};
  assign trial_w = {rem_r, num_lo_r[OB-1]};
  assign ge_w    = (trial_w >= {1'b0, span_r});

  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    diff_nxt   = diff_r;
    span_nxt   = span_r;
    last_nxt   = last_r;
    rem_nxt    = rem_r;
    num_lo_nxt = num_lo_r;
    quot_nxt   = quot_r;
    cnt_nxt    = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          diff_nxt = job_data.diff;
          span_nxt = job_data.span;
          last_nxt = job_data.last;
          case (job_data.kind)
            mmcs_pkg::JOB_DIVIDE: state_nxt = ST_LOAD;
            mmcs_pkg::JOB_FULL: begin
              quot_nxt  = mmcs_pkg::OUT_FULL;
              state_nxt = ST_DONE;
            end
            default: begin
              quot_nxt  = mmcs_pkg::OUT_ZERO;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        rem_nxt    = num_w[NB-1:OB];
        num_lo_nxt = num_w[OB-1:0];
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt    = ge_w ? SB'(trial_w - {1'b0, span_r}) : trial_w[SB-1:0];
        num_lo_nxt = {num_lo_r[OB-2:0], 1'b0};
        quot_nxt   = {quot_r[OB-2:0], ge_w};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNW'(OB - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r   <= diff_nxt;
    span_r   <= span_nxt;
    last_r   <= last_nxt;
    rem_r    <= rem_nxt;
    num_lo_r <= num_lo_nxt;
    quot_r   <= quot_nxt;
    if (load_out) begin
      out_data_r.scaled_pixel <= quot_r;
      out_data_r.frame_done   <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
      job_pop |-> (state_r == ST_IDLE))
    else $error("job popped while scaler busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_stall) |-> !load_out)
    else $error("pending result overwritten");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (out_data_r.scaled_pixel <= mmcs_pkg::OUT_FULL))
    else $error("scaled pixel above full scale");

endmodule

// ----- src/min_max_contrast_stretch.sv -----
// Top level of the min/max contrast stretch block.
// Instantiates mmcs_front, mmcs_queue and mmcs_scaler; depends on mmcs_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  mmcs_pkg::in_item_t
//   out_     output     out_valid / out_stall mmcs_pkg::out_item_t
//
// A measure sample updates the tracked minimum and maximum and gives no result.
// A scale sample goes from IDLE straight to DONE in the scaler when it saturates or is
// zero, else through LOAD and the 16-step restoring divider, one job at a time.
// Reset (rst_n low, synchronous) loads the extreme tracking values and empties the queue.
// in_stall rises when the job queue is full; the output register holds a result
// while out_stall is high, and the scaler keeps working until it has a new one.
`timescale 1ns / 1ps

module min_max_contrast_stretch #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmcs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mmcs_pkg::out_item_t out_item
);

  // jobs from the front end to the scaler
  logic           job_push;
  mmcs_pkg::job_t job_push_data;
  logic           job_pop;
  mmcs_pkg::job_t job_pop_data;
  logic           queue_full;
  logic           queue_empty;

  // track min/max over measure transfers and classify scale transfers on the input side
  mmcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .job_push   (job_push),
    .job_data   (job_push_data),
    .queue_full (queue_full)
  );

  // decouple the front end from the iterative divider
  mmcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_push_data),
    .pop       (job_pop),
    .pop_data  (job_pop_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // divide, saturate and hold the result for the output transfer
  mmcs_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (queue_empty),
    .job_data  (job_pop_data),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
